@@ sv/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// Automaton step package
// Shared widths, register indexes, reset values and the result type.
// ----------------------------------------------------------------------------
package vna_pkg;

    // Default grid limits; the top level takes them as parameters.
    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_SIZE_W  = 11;
    localparam int COUNT_W     = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_LIVE = 2'd2;

    localparam logic [CFG_SIZE_W-1:0] GRID_SIZE_RST = 11'd1024;

    // Stream data widths (fields padded to whole bytes).
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    // One result beat.
    typedef struct packed {
        logic               keep_running;
        logic [COUNT_W-1:0] changed_count;
        logic [COUNT_W-1:0] live_count;
        logic               end_of_frame;
        logic               changed;
        logic               new_alive;
    } vna_result_t;

endpackage

@@ sv/vna_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/vna_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result output buffer
// Two-entry buffer that drives the master side, so a new result can be
// pushed while the previous one is still waiting to be taken.
// ----------------------------------------------------------------------------
module vna_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vna_pkg::vna_result_t din,
    output logic                room,
    output logic                valid,
    input  logic                ready,
    output vna_pkg::vna_result_t dout
);

    import vna_pkg::*;

    vna_result_t ent0_reg, ent0_next;
    vna_result_t ent1_reg, ent1_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign valid = (cnt_reg != 2'd0);
    assign room  = (cnt_reg != 2'd2);
    assign dout  = ent0_reg;
    assign pop   = valid && ready;

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    ent0_next = din;
                end
                else
                begin
                    ent1_next = din;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                ent0_next = ent1_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    ent0_next = din;
                end
                else
                begin
                    ent0_next = ent1_reg;
                    ent1_next = din;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

@@ sv/von_neumann_automaton_step.sv @@
// ----------------------------------------------------------------------------
// Von Neumann automaton step
// One generation of a binary 2D automaton over a raster stream of cells.
// ----------------------------------------------------------------------------
// The block takes one cell beat per clock cycle while s_tready is high. A
// frame is grid_rows rows of grid_cols cells in raster order followed by
// grid_cols padding beats; the beat after the padding closes the frame and
// restarts it. A cell lives in the next generation when it and its four
// nearest neighbours (outside the grid counts as dead) hold two, four or five
// live cells. The result of a cell is computed when the cell one row below it
// arrives and is pushed into the output buffer when the following input beat
// is accepted, so results trail the input by grid_cols+1 cells; the result of
// the grid's last cell carries tlast, the live and changed totals and the
// keep_running flag. The two previous rows live in one line-buffer RAM of
// MAX_COLS words, read one column ahead of the stream, which sets the rate of
// one cell per cycle. After reset s_tready stays low while the line buffer is
// cleared and while the read-ahead is primed (ST_PRIME0, ST_PRIME1); every
// configuration write after the clear repeats the priming.
// ----------------------------------------------------------------------------
module von_neumann_automaton_step #(
    parameter int MAX_ROWS = vna_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = vna_pkg::MAX_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [vna_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vna_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Cell stream in.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vna_pkg::S_TDATA_W-1:0]   s_tdata,  // [0] cell_alive, [7:1] zero
    input  logic                            s_tuser,  // [0] flush
    // Result stream out.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] new_alive, [1] changed, [22:2] live_count, [43:23] changed_count,
    // [44] keep_running, [47:45] zero
    output logic [vna_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast   // end_of_frame
);

    import vna_pkg::*;

    // Column address, column count, arithmetic and row position widths.
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int CW     = CNT_W + 1;
    localparam int RPOS_W = $clog2(MAX_ROWS + 2);

    // Sequencer states.
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_PRIME0 = 2'd1;
    localparam logic [1:0] ST_PRIME1 = 2'd2;
    localparam logic [1:0] ST_RUN    = 2'd3;

    // Configuration registers.
    logic [CFG_SIZE_W-1:0] grid_rows_reg;
    logic [CFG_SIZE_W-1:0] grid_cols_reg;
    logic [COUNT_W-1:0]    init_live_reg;

    // Control and datapath state.
    logic [1:0]        state_reg, state_next;
    logic [COL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [RPOS_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              west_reg, west_next;
    logic [COUNT_W-1:0] live_total_reg, live_total_next;
    logic [COUNT_W-1:0] chg_total_reg, chg_total_next;
    logic              held_valid_reg, held_valid_next;
    logic              held_alive_reg, held_alive_next;
    logic              held_changed_reg, held_changed_next;
    logic              held_last_reg, held_last_next;
    // Line-buffer word of the current column: [1] middle row, [0] upper row.
    logic [1:0]        cur_reg, cur_next;
    // Forwarded word when the read-ahead hit the column being written.
    logic              byp_valid_reg, byp_valid_next;
    logic [1:0]        byp_word_reg, byp_word_next;

    // Line-buffer RAM ports.
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [1:0]        ram_wdata;
    logic              ram_re;
    logic [COL_W-1:0]  ram_raddr;
    logic [1:0]        ram_rdata;

    // Effective sizes and position arithmetic.
    logic [CFG_SIZE_W-1:0] rows_c;
    logic [CFG_SIZE_W-1:0] cols_c;
    logic [RPOS_W-1:0] rows_eff;
    logic [CW-1:0]     cols_x;
    logic [CW-1:0]     col_x;
    logic [CW-1:0]     col_p1;
    logic [CW-1:0]     col_p2;
    logic [CW-1:0]     ahead_a;
    logic [CW-1:0]     ahead_b;
    logic [CW-1:0]     prime_c;
    logic [CW-1:0]     prime_c1;
    logic [CW-1:0]     col_wrap;
    logic              out_of_frame;
    logic              last_col;
    logic              east_ok;

    // Neighbourhood.
    logic [1:0]        east_word;
    logic              cell_v;
    logic              mid_bit;
    logic [2:0]        nb_sum;
    logic              alive;
    logic [1:0]        wr_word;

    // Handshake and results.
    logic              in_acc;
    logic              buf_room;
    logic              res_push;
    vna_result_t       res_in;
    vna_result_t       res_out;
    logic [22:0]       live_x3;
    logic [22:0]       live_x2;
    logic [22:0]       init_x3;
    logic [22:0]       init_x2;
    logic              stop_run;

    // ------------------------------------------------------------------
    // Configuration writes land directly; unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_SIZE_RST;
            grid_cols_reg <= GRID_SIZE_RST;
            init_live_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_ROWS:    grid_rows_reg <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_GRID_COLS:    grid_cols_reg <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_INITIAL_LIVE: init_live_reg <= cfg_wdata[COUNT_W-1:0];
                default:          grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sizes in use are clamped to 1..MAX. Column arithmetic runs one bit
    // wider than the count so that c+2 never overflows.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (grid_rows_reg == '0)
        begin
            rows_c = CFG_SIZE_W'(1);
        end
        else if (32'(grid_rows_reg) > MAX_ROWS)
        begin
            rows_c = CFG_SIZE_W'(MAX_ROWS);
        end
        else
        begin
            rows_c = grid_rows_reg;
        end

        if (grid_cols_reg == '0)
        begin
            cols_c = CFG_SIZE_W'(1);
        end
        else if (32'(grid_cols_reg) > MAX_COLS)
        begin
            cols_c = CFG_SIZE_W'(MAX_COLS);
        end
        else
        begin
            cols_c = grid_cols_reg;
        end
    end

    assign rows_eff = RPOS_W'(rows_c);
    assign cols_x   = CW'(cols_c);
    assign col_x    = CW'(col_reg);
    assign col_p1   = col_x + CW'(1);
    assign col_p2   = col_x + CW'(2);

    // A position beyond the sizes closes the frame (normal end after the
    // padding row, or sizes shrunk under a running frame).
    assign out_of_frame = (row_reg > rows_eff) || (col_x >= cols_x);
    assign last_col     = (col_p1 >= cols_x);
    assign east_ok      = (col_p1 < cols_x);
    assign col_wrap     = last_col ? '0 : col_p1;

    // Read-ahead address (c+2) mod cols; two steps cover a one-column grid.
    assign ahead_a = (col_p2 >= cols_x) ? (col_p2 - cols_x) : col_p2;
    assign ahead_b = (ahead_a >= cols_x) ? (ahead_a - cols_x) : ahead_a;

    // Priming starts at the column the next accepted cell will use.
    assign prime_c  = out_of_frame ? '0 : col_x;
    assign prime_c1 = ((prime_c + CW'(1)) >= cols_x) ? '0 : (prime_c + CW'(1));

    // ------------------------------------------------------------------
    // Neighbourhood of the cell one row above the incoming one.
    // cur_reg holds its line-buffer word, the RAM output holds the word of
    // the column to its east.
    // ------------------------------------------------------------------
    assign east_word = byp_valid_reg ? byp_word_reg : ram_rdata;
    assign mid_bit   = cur_reg[1];
    // Padding beats and flagged cells count as dead.
    assign cell_v    = (row_reg < rows_eff) ? (s_tdata[0] & ~s_tuser) : 1'b0;
    assign wr_word   = {cell_v, mid_bit};

    always_comb
    begin
        nb_sum = 3'(mid_bit) + 3'(cell_v);
        if (row_reg > RPOS_W'(1))
        begin
            nb_sum = nb_sum + 3'(cur_reg[0]);
        end
        if (col_reg != '0)
        begin
            nb_sum = nb_sum + 3'(west_reg);
        end
        if (east_ok)
        begin
            nb_sum = nb_sum + 3'(east_word[1]);
        end
        alive = nb_sum inside {3'd2, 3'd4, 3'd5};
    end

    assign s_tready = (state_reg == ST_RUN) && buf_room;
    assign in_acc   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Sequencer and per-beat state update.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        west_next         = west_reg;
        live_total_next   = live_total_reg;
        chg_total_next    = chg_total_reg;
        held_valid_next   = held_valid_reg;
        held_alive_next   = held_alive_reg;
        held_changed_next = held_changed_reg;
        held_last_next    = held_last_reg;
        cur_next          = cur_reg;
        byp_valid_next    = byp_valid_reg;
        byp_word_next     = byp_word_reg;
        ram_we            = 1'b0;
        ram_waddr         = col_reg;
        ram_wdata         = wr_word;
        ram_re            = 1'b0;
        ram_raddr         = COL_W'(ahead_b);

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero the line buffer, one column per cycle.
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == COL_W'(MAX_COLS - 1))
                begin
                    state_next = ST_PRIME0;
                end
            end
            ST_PRIME0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = COL_W'(prime_c);
                state_next = ST_PRIME1;
            end
            ST_PRIME1:
            begin
                ram_re         = 1'b1;
                ram_raddr      = COL_W'(prime_c1);
                cur_next       = ram_rdata;
                byp_valid_next = 1'b0;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                if (in_acc)
                begin
                    if (out_of_frame)
                    begin
                        // Frame restart; the read-ahead already points at
                        // column zero.
                        row_next        = '0;
                        col_next        = '0;
                        west_next       = 1'b0;
                        live_total_next = '0;
                        chg_total_next  = '0;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_re    = 1'b1;
                        // From the second row on, a result is produced.
                        held_valid_next = (row_reg != '0);
                        if (row_reg != '0)
                        begin
                            held_alive_next   = alive;
                            held_changed_next = alive ^ mid_bit;
                            held_last_next    = (row_reg == rows_eff) && last_col;
                            live_total_next   = live_total_reg + COUNT_W'(alive);
                            chg_total_next    = chg_total_reg + COUNT_W'(alive ^ mid_bit);
                        end
                        west_next = mid_bit;
                        // On a one-column grid the next word is the one
                        // written right now.
                        if (COL_W'(col_wrap) == col_reg)
                        begin
                            cur_next = wr_word;
                        end
                        else
                        begin
                            cur_next = east_word;
                        end
                        // Read-ahead hitting the written column (narrow grids).
                        byp_valid_next = (COL_W'(ahead_b) == col_reg);
                        byp_word_next  = wr_word;
                        col_next = COL_W'(col_wrap);
                        if (last_col)
                        begin
                            row_next = row_reg + RPOS_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A new configuration may move the wrap point: prime again.
        if (cfg_we && (state_reg != ST_CLEAR))
        begin
            state_next = ST_PRIME0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            west_reg       <= 1'b0;
            live_total_reg <= '0;
            chg_total_reg  <= '0;
            held_valid_reg <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            west_reg       <= west_next;
            live_total_reg <= live_total_next;
            chg_total_reg  <= chg_total_next;
            held_valid_reg <= held_valid_next;
            byp_valid_reg  <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_alive_reg   <= held_alive_next;
        held_changed_reg <= held_changed_next;
        held_last_reg    <= held_last_next;
        cur_reg          <= cur_next;
        byp_word_reg     <= byp_word_next;
    end

    vna_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // A held result leaves when the next beat is accepted. The stop test
    // compares 3*live against 2*initial and 2*live against 3*initial
    // exactly, with shift-and-add products.
    // ------------------------------------------------------------------
    assign live_x2 = 23'({live_total_reg, 1'b0});
    assign live_x3 = live_x2 + 23'(live_total_reg);
    assign init_x2 = 23'({init_live_reg, 1'b0});
    assign init_x3 = init_x2 + 23'(init_live_reg);
    assign stop_run = (live_x3 <= init_x2) || (live_x2 > init_x3);

    always_comb
    begin
        res_in.new_alive    = held_alive_reg;
        res_in.changed      = held_changed_reg;
        res_in.end_of_frame = held_last_reg;
        if (held_last_reg)
        begin
            res_in.live_count    = live_total_reg;
            res_in.changed_count = chg_total_reg;
            res_in.keep_running  = ~stop_run;
        end
        else
        begin
            res_in.live_count    = '0;
            res_in.changed_count = '0;
            res_in.keep_running  = 1'b0;
        end
    end

    assign res_push = in_acc && held_valid_reg;

    vna_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .room  (buf_room),
        .valid (m_tvalid),
        .ready (m_tready),
        .dout  (res_out)
    );

    assign m_tdata = {3'b000, res_out.keep_running, res_out.changed_count,
                      res_out.live_count, res_out.changed, res_out.new_alive};
    assign m_tlast = res_out.end_of_frame;

endmodule

@@ sv/vna_checker.sv @@
// ----------------------------------------------------------------------------
// Automaton step checker
// Port-level assertions for the automaton step, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vna_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import vna_pkg::*;

    localparam int LIVE_LSB = 2;
    localparam int LIVE_MSB = 22;
    localparam int KEEP_BIT = 44;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Totals and the stop flag are zero except on the frame's last result.
    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[M_TDATA_W-1:LIVE_LSB] == '0))
        else $error("totals present on a result that is not the frame end");

    // An empty new generation always stops the run.
    a_dead_stops: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && (m_tdata[LIVE_MSB:LIVE_LSB] == '0) |-> !m_tdata[KEEP_BIT])
        else $error("keep_running set with no live cells");

    // A new result only shows up after an input beat was accepted.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted input beat");

endmodule

bind von_neumann_automaton_step vna_checker u_vna_checker (.*);

@@ tb/sv/von_neumann_automaton_step_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Von Neumann automaton step testbench
// Streams cell frames through the block and checks every result beat against
// a generation tracker that follows the same raster walk. It covers directed
// corner frames first, then random frames with random stalls on both sides.
// ----------------------------------------------------------------------------
module von_neumann_automaton_step_tb;
    import vna_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    // Cycles to wait after the last expected result before touching a
    // register. This covers the hold of the last computed cell and the
    // priming the block does after a write.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 300;

    // ------------------------------------------------------------------------
    // Generation tracker: follows the raster position, keeps the two previous
    // rows and the running totals, and queues the result each beat causes.
    // ------------------------------------------------------------------------
    class generation_tracker;
        bit [CFG_SIZE_W-1:0] rows_reg;
        bit [CFG_SIZE_W-1:0] cols_reg;
        bit [COUNT_W-1:0]    initial_live_reg;
        // Row stores start all dead; bit arrays default to zero.
        bit                  upper_row [MAX_COLS_DEF];
        bit                  middle_row [MAX_COLS_DEF];
        int unsigned         row_pos;
        int unsigned         col_pos;
        bit [COUNT_W-1:0]    live_sum;
        bit [COUNT_W-1:0]    changed_sum;
        bit                  west_cell;
        bit                  held_valid;
        bit                  held_alive;
        bit                  held_changed;
        bit                  held_last;
        vna_result_t         pending_results [$];
        int unsigned         fail_count;

        function new();
            rows_reg         = GRID_SIZE_RST;
            cols_reg         = GRID_SIZE_RST;
            initial_live_reg = '0;
            fail_count       = 0;
            begin_frame();
        endfunction

        function void begin_frame();
            row_pos     = 0;
            col_pos     = 0;
            live_sum    = '0;
            changed_sum = '0;
            west_cell   = 1'b0;
            held_valid  = 1'b0;
        endfunction

        // Sizes are clamped to 1..limit; the register keeps the raw value.
        function int unsigned size_in_use(bit [CFG_SIZE_W-1:0] value, int unsigned limit);
            if (value == 0)
                return 1;
            if (value > limit)
                return limit;
            return value;
        endfunction

        function int unsigned rows_in_use();
            return size_in_use(rows_reg, MAX_ROWS_DEF);
        endfunction

        function int unsigned cols_in_use();
            return size_in_use(cols_reg, MAX_COLS_DEF);
        endfunction

        function void set_register(bit [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] value);
            case (index)
                CFG_GRID_ROWS:    rows_reg = value[CFG_SIZE_W-1:0];
                CFG_GRID_COLS:    cols_reg = value[CFG_SIZE_W-1:0];
                CFG_INITIAL_LIVE: initial_live_reg = value[COUNT_W-1:0];
                default:          ;
            endcase
        endfunction

        // The held cell leaves on the next beat. Totals and the stop test are
        // only filled in on the frame's last cell, using the register value
        // at the time the result leaves.
        function void release_held_cell();
            vna_result_t     expected;
            longint unsigned live;
            longint unsigned base;
            if (!held_valid)
                return;
            expected              = '0;
            expected.new_alive    = held_alive;
            expected.changed      = held_changed;
            expected.end_of_frame = held_last;
            if (held_last)
            begin
                live                   = live_sum;
                base                   = initial_live_reg;
                expected.live_count    = live_sum;
                expected.changed_count = changed_sum;
                expected.keep_running  = !((3 * live <= 2 * base) || (2 * live > 3 * base));
            end
            pending_results.push_back(expected);
            held_valid = 1'b0;
        endfunction

        function void take_cell(bit alive, bit flush);
            int unsigned rows;
            int unsigned cols;
            int unsigned r;
            int unsigned c;
            int unsigned sum;
            bit          cell_bit;
            bit          mid;
            bit          up;
            bit          next_alive;
            rows = rows_in_use();
            cols = cols_in_use();
            r    = row_pos;
            c    = col_pos;
            // The beat after the padding row, or a position left outside the
            // grid by a size change, closes the frame without using its data.
            if (r > rows || c >= cols)
            begin
                release_held_cell();
                begin_frame();
                return;
            end
            release_held_cell();
            // A flush inside the grid and anything in the padding row are dead.
            cell_bit = (r < rows) ? (alive & ~flush) : 1'b0;
            mid      = middle_row[c];
            up       = upper_row[c];
            // The cell above the current beat is now complete: it has its
            // north, west, east and south neighbours.
            if (r >= 1)
            begin
                sum = int'(mid) + int'(cell_bit);
                if (r >= 2)
                    sum += up;
                if (c > 0)
                    sum += west_cell;
                if (c + 1 < cols)
                    sum += middle_row[c + 1];
                next_alive   = (sum == 2 || sum == 4 || sum == 5);
                held_valid   = 1'b1;
                held_alive   = next_alive;
                held_changed = next_alive ^ mid;
                held_last    = (r == rows && c + 1 == cols);
                live_sum    += next_alive;
                changed_sum += held_changed;
            end
            west_cell     = mid;
            upper_row[c]  = mid;
            middle_row[c] = cell_bit;
            c++;
            if (c >= cols)
            begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void check_beat(vna_result_t got);
            vna_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: new_alive %0d, end_of_frame %0d",
                       got.new_alive, got.end_of_frame);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.new_alive !== want.new_alive)
            begin
                $error("new_alive: expected %0d, got %0d", want.new_alive, got.new_alive);
                fail_count++;
            end
            if (got.changed !== want.changed)
            begin
                $error("changed: expected %0d, got %0d", want.changed, got.changed);
                fail_count++;
            end
            if (got.end_of_frame !== want.end_of_frame)
            begin
                $error("end_of_frame: expected %0d, got %0d",
                       want.end_of_frame, got.end_of_frame);
                fail_count++;
            end
            if (got.live_count !== want.live_count)
            begin
                $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
                fail_count++;
            end
            if (got.changed_count !== want.changed_count)
            begin
                $error("changed_count: expected %0d, got %0d",
                       want.changed_count, got.changed_count);
                fail_count++;
            end
            if (got.keep_running !== want.keep_running)
            begin
                $error("keep_running: expected %0d, got %0d",
                       want.keep_running, got.keep_running);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [0] cell_alive, [7:1] zero
    logic                   s_tuser   = 1'b0; // [0] flush
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] new_alive, [1] changed, [22:2] live_count, [43:23] changed_count,
    // [44] keep_running, [47:45] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;          // end_of_frame

    generation_tracker next_gen;
    int unsigned       items_sent     = 0;
    int unsigned       cycle_count    = 0;
    // Chance of an idle burst before a beat is 1 in this many; 0 means none.
    int unsigned       src_idle_odds  = 0;
    int unsigned       sink_idle_odds = 0;

    von_neumann_automaton_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit, far beyond the slowest correct run with every stall at its
    // longest, including the line-buffer clear after reset.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("von_neumann_automaton_step_tb: FAIL");
            $finish;
        end
    end

    // Receiver stalls: idle bursts of random length with m_tready low.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // A result beat is captured at the edge that accepts it and checked at the
    // following falling edge, once every cell accepted at that edge has been noted.
    always @(posedge clk)
    begin : result_watch
        vna_result_t beat;
        bit          taken;
        taken              = rst_n && m_tvalid && m_tready;
        beat.new_alive     = m_tdata[0];
        beat.changed       = m_tdata[1];
        beat.live_count    = m_tdata[22:2];
        beat.changed_count = m_tdata[43:23];
        beat.keep_running  = m_tdata[44];
        beat.end_of_frame  = m_tlast;
        if (taken)
        begin
            @(negedge clk);
            next_gen.check_beat(beat);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(bit [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        next_gen.set_register(index, value);
    endtask

    task automatic set_grid(bit [CFG_DATA_W-1:0] rows, bit [CFG_DATA_W-1:0] cols,
                            bit [CFG_DATA_W-1:0] base_live);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_INITIAL_LIVE, base_live);
    endtask

    // One cell beat, possibly after an idle burst. Returns at the accepting
    // edge with s_tvalid still high, so back-to-back beats leave no gap.
    task automatic send_cell(bit alive, bit flush);
        if (src_idle_odds != 0 && $urandom_range(1, src_idle_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, alive};
        s_tuser  <= flush;
        do
            @(posedge clk);
        while (!s_tready);
        next_gen.take_cell(alive, flush);
        items_sent++;
    endtask

    // Inside the grid cells are mostly clean with an odd flush; in the
    // padding the flag is mostly set and the cell bit is noise.
    task automatic send_random_item(int unsigned live_pct);
        bit alive;
        bit flush;
        if (next_gen.row_pos < next_gen.rows_in_use())
        begin
            alive = ($urandom_range(0, 99) < live_pct);
            flush = ($urandom_range(0, 19) == 0);
        end
        else
        begin
            alive = 1'($urandom_range(0, 1));
            flush = ($urandom_range(0, 7) != 0);
        end
        send_cell(alive, flush);
    endtask

    // Stop sending and wait until every expected result has left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (next_gen.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A whole frame from its first cell. With tune_stop the stream pauses
    // before the closing beat and initial_live is set right at one of the
    // stop-test boundaries for the live count the frame produced.
    task automatic run_frame(int unsigned live_pct, bit tune_stop);
        bit [CFG_DATA_W-1:0] base_live;
        longint unsigned     live;
        while (next_gen.row_pos <= next_gen.rows_in_use())
            send_random_item(live_pct);
        if (tune_stop)
        begin
            drain_results();
            live = next_gen.live_sum;
            case ($urandom_range(0, 3))
                0:       base_live = CFG_DATA_W'((3 * live) / 2);
                1:       base_live = CFG_DATA_W'((3 * live) / 2 + 1);
                2:       base_live = CFG_DATA_W'((2 * live) / 3);
                default: base_live = CFG_DATA_W'((2 * live + 2) / 3);
            endcase
            write_reg(CFG_INITIAL_LIVE, base_live);
        end
        send_random_item(live_pct);
    endtask

    // A frame cut short by a size change. Depending on where it was cut, the
    // next beat either closes the frame or the frame goes on at the new size.
    task automatic break_frame(int unsigned live_pct);
        int unsigned span;
        int unsigned cut;
        span = next_gen.rows_in_use() * next_gen.cols_in_use() + next_gen.cols_in_use() + 1;
        cut  = $urandom_range(1, span - 1);
        repeat (cut) send_random_item(live_pct);
        drain_results();
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_GRID_ROWS, CFG_DATA_W'($urandom_range(0, 4)));
        else
            write_reg(CFG_GRID_COLS, CFG_DATA_W'($urandom_range(0, 4)));
        do
            send_random_item(live_pct);
        while (next_gen.row_pos != 0 || next_gen.col_pos != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_start;
        int unsigned phase_rows;
        int unsigned phase_cols;
        int unsigned live_pct;

        next_gen = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_odds  = 4;
        sink_idle_odds = 4;

        // Two cells at the reset sizes, then a grid only two cells wide: the
        // stream sits past the last column, so the next beat closes the frame.
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        drain_results();
        set_grid(1, 2, 3);
        send_cell(1'b0, 1'b0);

        // One row of two live cells: both survive, two live, no change. An
        // initial count of three puts the live count exactly on the low stop
        // boundary. The padding carries a live bit with and without flush.
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b1);
        drain_results();

        // Two rows of three with a flushed live cell inside the grid, and the
        // largest initial count the register holds.
        set_grid(2, 3, {CFG_DATA_W{1'b1}});
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);

        // Same grid cut off in the padding row; a row count of zero (used as
        // one) leaves the position below the grid, so the next beat closes
        // the frame and releases the held cell.
        repeat (7) send_random_item(50);
        drain_results();
        write_reg(CFG_GRID_ROWS, 0);
        send_cell(1'b1, 1'b0);
        drain_results();

        // Clamped sizes: a zero row count with an oversized column count, cut
        // off partway along the row by narrowing the grid, then an oversized
        // row count over a single column, cut off by lowering the row count
        // so the next beat closes the frame and releases the held cell.
        set_grid(0, 2047, 1 << 20);
        repeat (40) send_random_item(50);
        drain_results();
        write_reg(CFG_GRID_COLS, 4);
        send_random_item(50);
        drain_results();
        set_grid(2047, 1, 5);
        repeat (30) send_random_item(50);
        drain_results();
        write_reg(CFG_GRID_ROWS, 3);
        send_random_item(50);
        drain_results();

        // Random phases: small grids, random density and stall rates, a few
        // frames back to back, now and then a frame cut short.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            phase_rows = $urandom_range(1, 8);
            phase_cols = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
                phase_rows = 0;
            if ($urandom_range(0, 9) == 0)
                phase_cols = 0;
            live_pct       = $urandom_range(10, 90);
            src_idle_odds  = $urandom_range(0, 2) * 4;
            sink_idle_odds = $urandom_range(0, 2) * 4;
            if ($urandom_range(0, 3) == 0)
                set_grid(CFG_DATA_W'(phase_rows), CFG_DATA_W'(phase_cols),
                         CFG_DATA_W'($urandom));
            else
                set_grid(CFG_DATA_W'(phase_rows), CFG_DATA_W'(phase_cols),
                         CFG_DATA_W'($urandom_range(0, phase_rows * phase_cols + 4)));
            repeat ($urandom_range(1, 3)) run_frame(live_pct, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0)
                break_frame(live_pct);
            drain_results();
        end

        // Last stretch at full rate on both sides.
        src_idle_odds  = 0;
        sink_idle_odds = 0;
        set_grid(6, 7, CFG_DATA_W'($urandom_range(0, 42)));
        run_frame(50, 1'b0);
        run_frame(30, 1'b1);
        drain_results();

        if (next_gen.fail_count == 0)
            $display("von_neumann_automaton_step_tb: PASS");
        else
            $display("von_neumann_automaton_step_tb: FAIL");
        $finish;
    end

endmodule
